>>> hw/rtl/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
`default_nettype none
package cbc_pkg;

  localparam int ROM_BANK_BITS = 9;
  localparam int RAM_BANK_BITS = 4;
  localparam int ROM_OFS_BITS  = 14;
  localparam int RAM_OFS_BITS  = 13;
  localparam int PHYS_W        = 23;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef enum logic [1:0] {
    KIND_ROM  = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC5 = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_RSVD = 2'd3
  } target_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MBC_KIND      = 2'd0,
    REG_ROM_BANK_MASK = 2'd1,
    REG_RAM_PRESENT   = 2'd2,
    REG_RAM_BANK_MASK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        op;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } in_t;

  typedef struct packed {
    logic [1:0]        target;
    logic [PHYS_W-1:0] physical_address;
    logic              is_store;
    logic [7:0]        store_byte;
  } out_t;

  typedef struct packed {
    kind_t                    mbc_kind;
    logic [ROM_BANK_BITS-1:0] rom_bank_mask;
    logic                     ram_present;
    logic [RAM_BANK_BITS-1:0] ram_bank_mask;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/cbc_cfg_regs.sv
// Configuration register file of the cartridge bank controller.
`default_nettype none
module cbc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [cbc_pkg::CFG_DATA_W-1:0] wr_data,
  output      cbc_pkg::cfg_t                  cfg
);
  import cbc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_MBC_KIND:      cfg_nxt.mbc_kind      = kind_t'(wr_data[1:0]);
        REG_ROM_BANK_MASK: cfg_nxt.rom_bank_mask = wr_data[ROM_BANK_BITS-1:0];
        REG_RAM_PRESENT:   cfg_nxt.ram_present   = wr_data[0];
        REG_RAM_BANK_MASK: cfg_nxt.ram_bank_mask = wr_data[RAM_BANK_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mbc_kind      <= KIND_ROM;
      cfg_r.rom_bank_mask <= ROM_BANK_BITS'(1);
      cfg_r.ram_present   <= 1'b0;
      cfg_r.ram_bank_mask <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/cbc_xlate.sv
// Bank registers and address translation for one bus access.
`default_nettype none
module cbc_xlate (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   fire,
  input  wire cbc_pkg::in_t  acc,
  input  wire cbc_pkg::cfg_t cfg,
  output cbc_pkg::out_t res
);
  import cbc_pkg::*;

  logic                     ram_enabled_r, ram_enabled_nxt;
  logic [7:0]               rom_bank_low_r, rom_bank_low_nxt;
  logic                     rom_bank_high_r, rom_bank_high_nxt;
  logic [RAM_BANK_BITS-1:0] ram_bank_r, ram_bank_nxt;
  logic                     banking_mode_r, banking_mode_nxt;

  logic [4:0]               mbc1_lo;
  logic [ROM_BANK_BITS-1:0] rom_bank;
  logic [RAM_BANK_BITS-1:0] ram_bank_sel;
  logic                     is_mbc;
  logic [15:0]              addr;

  assign addr    = acc.bus_address;
  assign mbc1_lo = (rom_bank_low_r[4:0] == 5'd0) ? 5'd1 : rom_bank_low_r[4:0];
  assign is_mbc  = (cfg.mbc_kind == KIND_MBC1) || (cfg.mbc_kind == KIND_MBC5);

  always_comb begin
    rom_bank = '0;
    case (cfg.mbc_kind)
      KIND_MBC1: begin
        rom_bank = {2'b00, ram_bank_r[1:0], 5'd0};
        if (addr[14]) begin
          rom_bank = {2'b00, ram_bank_r[1:0], mbc1_lo};
        end else if (!banking_mode_r) begin
          rom_bank = '0;
        end
      end
      KIND_MBC5: begin
        if (addr[14]) begin
          rom_bank = {rom_bank_high_r, rom_bank_low_r};
        end
      end
      default: rom_bank = '0;
    endcase
  end

  always_comb begin
    ram_bank_sel = ram_bank_r;
    if (cfg.mbc_kind == KIND_MBC1) begin
      ram_bank_sel = banking_mode_r ? {2'b00, ram_bank_r[1:0]} : '0;
    end
  end

  always_comb begin
    res               = '0;
    ram_enabled_nxt   = ram_enabled_r;
    rom_bank_low_nxt  = rom_bank_low_r;
    rom_bank_high_nxt = rom_bank_high_r;
    ram_bank_nxt      = ram_bank_r;
    banking_mode_nxt  = banking_mode_r;
    if (!addr[15]) begin
      if (acc.op == OP_WRITE) begin
        case (cfg.mbc_kind)
          KIND_MBC1: begin
            case (addr[14:13])
              2'd0: ram_enabled_nxt = (acc.bus_data[3:0] == RAM_EN_KEY);
              2'd1: rom_bank_low_nxt =
                      {3'b000, (acc.bus_data[4:0] == 5'd0) ? 5'd1 : acc.bus_data[4:0]};
              2'd2: ram_bank_nxt = {2'b00, acc.bus_data[1:0]};
              default: banking_mode_nxt = acc.bus_data[0];
            endcase
          end
          KIND_MBC5: begin
            case (addr[14:13])
              2'd0: ram_enabled_nxt = (acc.bus_data[3:0] == RAM_EN_KEY);
              2'd1: begin
                if (addr[12]) begin
                  rom_bank_high_nxt = acc.bus_data[0];
                end else begin
                  rom_bank_low_nxt = acc.bus_data;
                end
              end
              2'd2: ram_bank_nxt = acc.bus_data[RAM_BANK_BITS-1:0];
              default: ram_bank_nxt = ram_bank_r;
            endcase
          end
          default: ram_bank_nxt = ram_bank_r;
        endcase
      end else begin
        res.target = TGT_ROM;
        if (is_mbc) begin
          res.physical_address = {rom_bank & cfg.rom_bank_mask, addr[ROM_OFS_BITS-1:0]};
        end else begin
          res.physical_address = {(PHYS_W-15)'(0), addr[14:0]};
        end
      end
    end else if (addr[15:13] == 3'b101) begin
      if (is_mbc && cfg.ram_present && ram_enabled_r) begin
        res.target           = TGT_RAM;
        res.physical_address = {(PHYS_W-RAM_BANK_BITS-RAM_OFS_BITS)'(0),
                                ram_bank_sel & cfg.ram_bank_mask,
                                addr[RAM_OFS_BITS-1:0]};
        if (acc.op == OP_WRITE) begin
          res.is_store   = 1'b1;
          res.store_byte = acc.bus_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enabled_r   <= 1'b0;
      rom_bank_low_r  <= 8'd1;
      rom_bank_high_r <= 1'b0;
      ram_bank_r      <= '0;
      banking_mode_r  <= 1'b0;
    end else if (fire) begin
      ram_enabled_r   <= ram_enabled_nxt;
      rom_bank_low_r  <= rom_bank_low_nxt;
      rom_bank_high_r <= rom_bank_high_nxt;
      ram_bank_r      <= ram_bank_nxt;
      banking_mode_r  <= banking_mode_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cartridge_bank_controller.sv
// Top level of the cartridge bank controller.
// Takes one CPU bus access per beat and returns one translated access per beat:
// target (none, ROM or RAM), physical byte address, and a RAM store flag with
// its byte. Writes below 0x8000 return target none and, for MBC1 and MBC5,
// update the bank registers. Result valid rises once the beat has passed the
// input register, then the result register; sustained rate is one beat per
// cycle, limited only by the output consumer. The config port is always ready.
`default_nettype none
module cartridge_bank_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire cbc_pkg::in_t                   in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output cbc_pkg::out_t                       out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbc_pkg::*;

  cfg_t cfg;
  in_t  acc_r;
  logic acc_valid_r;
  out_t res;
  out_t res_r;
  logic res_valid_r;
  logic adv;

  assign cfg_ready = 1'b1;

  cbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // stage advances when the result register is empty or being drained
  assign adv      = acc_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !acc_valid_r || adv;

  cbc_xlate u_xlate (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .acc   (acc_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        acc_valid_r <= in_valid;
      end
      if (adv) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_r <= in_data;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire
